// File: rtl/srdt_pkg.sv
// shared types and constants of the sensor reading to display text block
`timescale 1ns / 1ps
`default_nettype none

package srdt_pkg;

    // text run layout
    localparam int unsigned TXT_MAX  = 12;
    localparam int unsigned HUM_LEN  = 4;
    localparam int unsigned TAIL_LEN = 4;
    localparam int unsigned LEN_W    = $clog2(TXT_MAX + 1);
    localparam int unsigned IDX_W    = $clog2(TXT_MAX);
    localparam int unsigned Q_DEPTH  = 4;

    // display bytes
    localparam logic [7:0] CH_CMD   = 8'h40;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_BLANK = 8'hA0;
    localparam logic [3:0] CH_DIGIT = 4'h3;

    // scaling
    localparam logic [5:0]  HUM_MASK    = 6'b111111;
    localparam logic [6:0]  HUM_SCALE   = 7'd100;
    localparam logic [14:0] TEMP_SPAN   = 15'd16500;
    localparam logic [13:0] FULL_SCALE  = 14'd16382;
    localparam logic [13:0] TEMP_OFFSET = 14'd4000;
    localparam logic [13:0] ROUND_HALF  = 14'd5;
    localparam logic [3:0]  TEN         = 4'd10;
    localparam logic [6:0]  HUNDRED     = 7'd100;

    // reciprocals: floor(2^30/16382), ceil(2^19/10), ceil(2^11/10)
    localparam logic [16:0] RECIP_FS  = 17'd65544;
    localparam logic [16:0] RECIP_10  = 17'd52429;
    localparam logic [7:0]  RECIP_10N = 8'd205;

    typedef logic [TXT_MAX-1:0][7:0] t_text;

    typedef struct packed {
        t_text            text;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        logic   full;
        t_entry entry;
    } t_head;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = {CH_DIGIT, d};
    endfunction

endpackage

`default_nettype wire

// File: rtl/srdt_in_if.sv
// handshake channel carrying one four-byte sensor reading
`timescale 1ns / 1ps
`default_nettype none

interface srdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hum_raw_high;
    logic [7:0] hum_raw_low;
    logic [7:0] temp_raw_high;
    logic [7:0] temp_raw_low;

    modport source (
        output valid, hum_raw_high, hum_raw_low, temp_raw_high, temp_raw_low,
        input  ready
    );
    modport sink (
        input  valid, hum_raw_high, hum_raw_low, temp_raw_high, temp_raw_low,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/srdt_out_if.sv
// handshake channel carrying one display text byte
`timescale 1ns / 1ps
`default_nettype none

interface srdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_select;
    logic       last_byte;

    modport source (
        output valid, text_byte, line_select, last_byte,
        input  ready
    );
    modport sink (
        input  valid, text_byte, line_select, last_byte,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/srdt_front.sv
// front end: takes readings, scales them and builds the text run
`timescale 1ns / 1ps
`default_nettype none

module srdt_front #(
    parameter int unsigned DEPTH = srdt_pkg::Q_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    srdt_in_if.sink            i_rd,
    input  wire logic          i_pop,
    output srdt_pkg::t_push    o_push
);
    import srdt_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // items in flight: pipeline plus queue
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_acc;
    logic [6:0]    r_v;

    assign i_rd.ready = (r_cnt < CW'(DEPTH));
    assign w_acc      = i_rd.valid && i_rd.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_acc && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_acc && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v   <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_v   <= {r_v[5:0], w_acc};
        end
    end

    // stage 1: raw times scale
    logic [13:0] w_hraw;
    logic [15:0] w_traw;
    logic [20:0] r1_hx;
    logic [28:0] r1_tx;

    assign w_hraw = {i_rd.hum_raw_high[5:0] & HUM_MASK, i_rd.hum_raw_low};
    assign w_traw = {i_rd.temp_raw_high, i_rd.temp_raw_low};

    always_ff @(posedge i_clk) begin
        r1_hx <= 21'(w_hraw) * 21'(HUM_SCALE);
        r1_tx <= 29'(w_traw[15:2]) * 29'(TEMP_SPAN);
    end

    // stage 2: quotient estimate by reciprocal
    logic [37:0] w_hp;
    logic [45:0] w_tp;
    logic [20:0] r2_hx;
    logic [28:0] r2_tx;
    logic [6:0]  r2_hq0;
    logic [14:0] r2_tq0;

    assign w_hp = 38'(r1_hx) * 38'(RECIP_FS);
    assign w_tp = 46'(r1_tx) * 46'(RECIP_FS);

    always_ff @(posedge i_clk) begin
        r2_hx  <= r1_hx;
        r2_tx  <= r1_tx;
        r2_hq0 <= w_hp[36:30];
        r2_tq0 <= w_tp[44:30];
    end

    // stage 3: remainder check, estimate is low by at most one
    logic [20:0] w_hr;
    logic [28:0] w_tr;
    logic [6:0]  r3_hq;
    logic [14:0] r3_tq;

    assign w_hr = r2_hx - 21'(r2_hq0) * 21'(FULL_SCALE);
    assign w_tr = r2_tx - 29'(r2_tq0) * 29'(FULL_SCALE);

    always_ff @(posedge i_clk) begin
        r3_hq <= r2_hq0 + {6'd0, (w_hr >= 21'(FULL_SCALE))};
        r3_tq <= r2_tq0 + {14'd0, (w_tr >= 29'(FULL_SCALE))};
    end

    // stage 4: offset, sign, magnitude plus rounding half; humidity tens
    logic        w_neg;
    logic [13:0] w_mag;
    logic [14:0] w_ht;
    logic [6:0]  r4_hq;
    logic [3:0]  r4_htens;
    logic        r4_neg;
    logic [13:0] r4_y;

    assign w_neg = (r3_tq < 15'(TEMP_OFFSET));
    assign w_mag = w_neg ? 14'(15'(TEMP_OFFSET) - r3_tq) : 14'(r3_tq - 15'(TEMP_OFFSET));
    assign w_ht  = 15'(r3_hq) * 15'(RECIP_10N);

    always_ff @(posedge i_clk) begin
        r4_hq    <= r3_hq;
        r4_htens <= w_ht[14:11];
        r4_neg   <= w_neg;
        r4_y     <= w_mag + ROUND_HALF;
    end

    // stage 5: tenths; humidity characters
    logic [30:0]     w_tn;
    logic [6:0]      w_hrem;
    logic [2:0][7:0] w_hum;
    logic [2:0][7:0] r5_hum;
    logic            r5_neg;
    logic [10:0]     r5_tenths;

    assign w_tn   = 31'(r4_y) * 31'(RECIP_10);
    assign w_hrem = r4_hq - 7'(r4_htens) * 7'(TEN);

    always_comb begin
        if (r4_hq >= HUNDRED) begin
            w_hum = {digit_char(4'd1), digit_char(4'd0), digit_char(4'd0)};
        end else if (r4_hq >= 7'(TEN)) begin
            w_hum = {CH_BLANK, digit_char(r4_htens), digit_char(w_hrem[3:0])};
        end else begin
            w_hum = {CH_BLANK, CH_BLANK, digit_char(w_hrem[3:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        r5_hum    <= w_hum;
        r5_neg    <= r4_neg;
        r5_tenths <= w_tn[29:19];
    end

    // stage 6: integer part
    logic [27:0]     w_ip;
    logic [2:0][7:0] r6_hum;
    logic            r6_neg;
    logic [10:0]     r6_tenths;
    logic [6:0]      r6_ipart;

    assign w_ip = 28'(r5_tenths) * 28'(RECIP_10);

    always_ff @(posedge i_clk) begin
        r6_hum    <= r5_hum;
        r6_neg    <= r5_neg;
        r6_tenths <= r5_tenths;
        r6_ipart  <= w_ip[25:19];
    end

    // stage 7: tenths digit and integer part over ten
    logic [10:0]     w_frac;
    logic [14:0]     w_d1;
    logic [2:0][7:0] r7_hum;
    logic            r7_neg;
    logic [6:0]      r7_ipart;
    logic [3:0]      r7_frac;
    logic [3:0]      r7_d1;

    assign w_frac = r6_tenths - 11'(r6_ipart) * 11'(TEN);
    assign w_d1   = 15'(r6_ipart) * 15'(RECIP_10N);

    always_ff @(posedge i_clk) begin
        r7_hum   <= r6_hum;
        r7_neg   <= r6_neg;
        r7_ipart <= r6_ipart;
        r7_frac  <= w_frac[3:0];
        r7_d1    <= w_d1[14:11];
    end

    // build the run: integer part is at most 125, so hundreds is one
    logic [6:0]       w_ones;
    logic             w_nh;
    logic             w_nt;
    logic [3:0]       w_tens;
    logic [IDX_W-1:0] w_p;
    t_text            w_text;

    assign w_ones = r7_ipart - 7'(r7_d1) * 7'(TEN);
    assign w_nh   = (r7_d1 >= TEN);
    assign w_nt   = (r7_d1 != 4'd0);
    assign w_tens = w_nh ? (r7_d1 - TEN) : r7_d1;

    always_comb begin
        w_text    = '{default: CH_END};
        w_text[0] = CH_CMD;
        w_text[1] = r7_hum[2];
        w_text[2] = r7_hum[1];
        w_text[3] = r7_hum[0];
        w_text[IDX_W'(HUM_LEN)] = CH_CMD;
        w_p = IDX_W'(HUM_LEN + 1);
        if (r7_neg) begin
            w_text[w_p] = CH_MINUS;
            w_p = w_p + IDX_W'(1);
        end
        if (w_nh) begin
            w_text[w_p] = digit_char(4'd1);
            w_p = w_p + IDX_W'(1);
        end
        if (w_nt) begin
            w_text[w_p] = digit_char(w_tens);
            w_p = w_p + IDX_W'(1);
        end
        w_text[w_p] = digit_char(w_ones[3:0]);
        w_text[w_p + IDX_W'(1)] = CH_COMMA;
        w_text[w_p + IDX_W'(2)] = digit_char(r7_frac);
        w_text[w_p + IDX_W'(3)] = CH_END;
    end

    assign o_push.valid      = r_v[6];
    assign o_push.entry.text = w_text;
    assign o_push.entry.len  = LEN_W'(w_p) + LEN_W'(TAIL_LEN);

endmodule

`default_nettype wire

// File: rtl/srdt_queue.sv
// short queue of finished text runs between front and back
`timescale 1ns / 1ps
`default_nettype none

module srdt_queue #(
    parameter int unsigned DEPTH = srdt_pkg::Q_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srdt_pkg::t_push i_push,
    input  wire logic            i_pop,
    output srdt_pkg::t_head      o_head
);
    import srdt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.valid) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= wrap_inc(r_rp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.full  = (r_cnt == CW'(DEPTH));
    assign o_head.entry = r_mem[r_rp];

endmodule

`default_nettype wire

// File: rtl/srdt_back.sv
// back end: sends the head run out one byte per cycle while o_txt.ready is high
`timescale 1ns / 1ps
`default_nettype none

module srdt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srdt_pkg::t_head i_head,
    output logic                 o_pop,
    srdt_out_if.source           o_txt
);
    import srdt_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    logic [7:0]       r_byte;
    logic             r_line;
    logic             r_last;
    logic             w_load;
    logic             w_last;

    assign w_load = i_head.valid && (!r_ov || o_txt.ready);
    assign w_last = (r_idx == IDX_W'(i_head.entry.len - LEN_W'(1)));
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov  <= 1'b1;
                r_idx <= w_last ? '0 : r_idx + IDX_W'(1);
            end else if (o_txt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_head.entry.text[r_idx];
            r_line <= (r_idx >= IDX_W'(HUM_LEN));
            r_last <= w_last;
        end
    end

    assign o_txt.valid       = r_ov;
    assign o_txt.text_byte   = r_byte;
    assign o_txt.line_select = r_line;
    assign o_txt.last_byte   = r_last;

endmodule

`default_nettype wire

// File: rtl/sensor_reading_to_display_text.sv
// top level: sensor reading in, humidity and temperature display text out
//
// i_rd carries one four-byte reading from a humidity/temperature sensor;
// o_txt carries the display bytes it turns into, first the humidity line
// (command byte plus three characters, line_select low), then the
// temperature line (command byte, optional minus, one to three digits,
// comma, tenths digit, terminating zero, line_select high). last_byte marks
// the final byte of each reading's run.
// the first byte of a reading passes the scaling pipeline, the queue and
// the output register; its 9 to 11 bytes follow one per cycle while
// o_txt.ready is high; the byte serializer sets the rate of readings.
// the front end is a 7-stage scaling pipeline and takes a new reading every
// cycle as long as fewer than DEPTH readings are in flight or queued.
// a receiver stall holds the output register; once DEPTH readings are in
// flight or queued, i_rd.ready drops. no byte is lost or repeated.
// reset (synchronous, active low) empties the pipeline, queue and output.
`timescale 1ns / 1ps
`default_nettype none

module sensor_reading_to_display_text #(
    parameter int unsigned DEPTH = srdt_pkg::Q_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srdt_in_if.sink     i_rd,
    srdt_out_if.source  o_txt
);
    import srdt_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_pop;

    // scaling, digit split and run assembly
    srdt_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (i_rd),
        .i_pop   (w_pop),
        .o_push  (w_push)
    );

    // finished runs wait here while the receiver stalls
    srdt_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // byte serializer with output register
    srdt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_txt   (o_txt)
    );

    // the in-flight limit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid && !w_pop |-> !w_head.full)
        else $error("text queue written while full");

    // the run always ends on the temperature line
    a_last_on_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_txt.valid && o_txt.last_byte |-> o_txt.line_select)
        else $error("last byte outside the temperature line");

    // a run is only taken from the queue when it was there
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_txt.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// File: sim/tb_sensor_reading_to_display_text.sv
// testbench: sensor readings in, display text bytes checked against a predictor
`timescale 1ns / 1ps

module tb_sensor_reading_to_display_text;

    import srdt_pkg::*;

    // one expected display byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_select;
        logic       last_byte;
    } t_display_byte;

    // one directed reading; text is typed in only where typed is set
    typedef struct packed {
        logic [7:0]       hum_hi, hum_lo, temp_hi, temp_lo;
        logic             typed;
        logic [3:0]       len;
        logic [0:11][7:0] text;
    } t_reading_case;

    localparam int unsigned DIRECTED_N    = 13;
    localparam int unsigned RANDOM_PER_PH = 120;
    localparam int unsigned DRAIN_CYCLES  = 24;

    // scaling, as plain integers
    localparam int unsigned HUM_PCT   = 100;
    localparam int unsigned SPAN_CNT  = 16500;
    localparam int unsigned FULL_CNT  = 16382;
    localparam int          OFFSET_CH = 4000;

    localparam t_reading_case DIRECTED [DIRECTED_N] = '{
        // after reset, all bytes zero: "  0" and "-40,0"
        '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 4'd11,
          {8'h40, 8'hA0, 8'hA0, 8'h30, 8'h40, 8'h2D, 8'h34, 8'h30,
           8'h2C, 8'h30, 8'h00, 8'h00}},
        // all bytes full: "100" and "125,0"
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd11,
          {8'h40, 8'h31, 8'h30, 8'h30, 8'h40, 8'h31, 8'h32, 8'h35,
           8'h2C, 8'h30, 8'h00, 8'h00}},
        '{8'h3F, 8'hFE, 8'h00, 8'h00, 1'b0, 4'd0, '0},  // humidity exactly full scale
        '{8'h3F, 8'hFD, 8'h3E, 8'h10, 1'b0, 4'd0, '0},  // 99 percent, zero degrees
        '{8'h06, 8'h67, 8'h3E, 8'h00, 1'b0, 4'd0, '0},  // 10 percent, small negative to -0,0
        '{8'h06, 8'h66, 8'h3D, 8'hFC, 1'b0, 4'd0, '0},  // 9 percent, -0,1
        '{8'hC0, 8'h00, 8'h5D, 8'h04, 1'b0, 4'd0, '0},  // top humidity bits ignored, carry
        '{8'h80, 8'h01, 8'h5D, 8'h03, 1'b0, 4'd0, '0},  // low temp bits ignored, 19,9
        '{8'h15, 8'h55, 8'hD9, 8'h1C, 1'b0, 4'd0, '0},  // carry into hundreds: 100,0
        '{8'h2A, 8'hAA, 8'hD9, 8'h18, 1'b0, 4'd0, '0},  // just below: 99,9
        '{8'h00, 8'hFF, 8'hFF, 8'hFC, 1'b0, 4'd0, '0},  // one percent, top temperature
        '{8'h3F, 8'h00, 8'h80, 8'h00, 1'b0, 4'd0, '0},  // mid scale
        '{8'h40, 8'h00, 8'h3E, 8'h14, 1'b0, 4'd0, '0}   // just above zero
    };

    logic i_clk;
    logic i_rst_n;

    srdt_in_if  rd_if ();
    srdt_out_if txt_if ();

    sensor_reading_to_display_text dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_if),
        .o_txt   (txt_if)
    );

    t_display_byte text_due [$];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatch_count     = 0;
    int unsigned readings_taken     = 0;
    int unsigned bytes_checked      = 0;
    int unsigned below_zero_seen    = 0;
    int unsigned hundreds_seen      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_sensor_reading_to_display_text failed");
        $finish;
    end

    function automatic logic [7:0] ascii_digit(input int unsigned d);
        ascii_digit = {CH_DIGIT, 4'(d)};
    endfunction

    function automatic void expect_byte(input logic [7:0] ch, input logic line,
                                        input logic last);
        t_display_byte b;
        b.text_byte   = ch;
        b.line_select = line;
        b.last_byte   = last;
        text_due.push_back(b);
    endfunction

    // works out both display lines of one reading
    function automatic void render_reading(input logic [7:0] hum_hi, hum_lo,
                                           input logic [7:0] temp_hi, temp_lo);
        int unsigned hum;
        int unsigned raw;
        int          centi;
        logic        negative;
        int unsigned mag;
        int unsigned tenths;
        int unsigned ipart;

        // humidity line: leading zeros blanked
        hum = int'({hum_hi[5:0], hum_lo}) * HUM_PCT / FULL_CNT;
        expect_byte(CH_CMD, 1'b0, 1'b0);
        if (hum >= 100) begin
            expect_byte(ascii_digit(1), 1'b0, 1'b0);
            expect_byte(ascii_digit(0), 1'b0, 1'b0);
            expect_byte(ascii_digit(0), 1'b0, 1'b0);
        end else if (hum >= 10) begin
            expect_byte(CH_BLANK, 1'b0, 1'b0);
            expect_byte(ascii_digit(hum / 10), 1'b0, 1'b0);
            expect_byte(ascii_digit(hum % 10), 1'b0, 1'b0);
        end else begin
            expect_byte(CH_BLANK, 1'b0, 1'b0);
            expect_byte(CH_BLANK, 1'b0, 1'b0);
            expect_byte(ascii_digit(hum), 1'b0, 1'b0);
        end

        // temperature line: magnitude rounded half up to tenths, sign kept
        raw      = int'({temp_hi, temp_lo}) >> 2;
        centi    = int'(raw * SPAN_CNT / FULL_CNT) - OFFSET_CH;
        negative = centi < 0;
        mag      = negative ? -centi : centi;
        tenths   = (mag + 5) / 10;
        ipart    = tenths / 10;
        if (negative) below_zero_seen++;
        if (ipart >= 100) hundreds_seen++;

        expect_byte(CH_CMD, 1'b1, 1'b0);
        if (negative) expect_byte(CH_MINUS, 1'b1, 1'b0);
        if (ipart >= 100) expect_byte(ascii_digit((ipart / 100) % 10), 1'b1, 1'b0);
        if (ipart >= 10) expect_byte(ascii_digit((ipart / 10) % 10), 1'b1, 1'b0);
        expect_byte(ascii_digit(ipart % 10), 1'b1, 1'b0);
        expect_byte(CH_COMMA, 1'b1, 1'b0);
        expect_byte(ascii_digit(tenths % 10), 1'b1, 1'b0);
        expect_byte(CH_END, 1'b1, 1'b1);
    endfunction

    // holds the reading on the channel until taken, then records its text
    task automatic offer_reading(input t_reading_case row);
        while ($urandom_range(99) < sender_idle_pct) begin
            rd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rd_if.valid         <= 1'b1;
        rd_if.hum_raw_high  <= row.hum_hi;
        rd_if.hum_raw_low   <= row.hum_lo;
        rd_if.temp_raw_high <= row.temp_hi;
        rd_if.temp_raw_low  <= row.temp_lo;
        do @(posedge i_clk); while (!rd_if.ready);
        if (row.typed) begin
            for (int k = 0; k < row.len; k++)
                expect_byte(row.text[k], k >= HUM_LEN, k == row.len - 1);
        end else begin
            render_reading(row.hum_hi, row.hum_lo, row.temp_hi, row.temp_lo);
        end
        readings_taken++;
    endtask

    // output side: random stalls, every taken byte checked in order
    always @(posedge i_clk) begin
        t_display_byte want;
        if (i_rst_n && txt_if.valid && txt_if.ready) begin
            if (text_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected text byte %h line %b last %b", $time,
                         txt_if.text_byte, txt_if.line_select, txt_if.last_byte);
            end else begin
                want = text_due.pop_front();
                bytes_checked++;
                if (txt_if.text_byte !== want.text_byte
                        || txt_if.line_select !== want.line_select
                        || txt_if.last_byte !== want.last_byte) begin
                    mismatch_count++;
                    $display("%0t: expected byte %h line %b last %b, got byte %h line %b last %b",
                             $time, want.text_byte, want.line_select, want.last_byte,
                             txt_if.text_byte, txt_if.line_select, txt_if.last_byte);
                end
            end
        end
        txt_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        t_reading_case row;
        logic [13:0]   hum_code;
        logic [13:0]   temp_code;
        int unsigned   pick;

        i_rst_n             <= 1'b0;
        rd_if.valid         <= 1'b0;
        rd_if.hum_raw_high  <= '0;
        rd_if.hum_raw_low   <= '0;
        rd_if.temp_raw_high <= '0;
        rd_if.temp_raw_low  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling on either side
        for (int i = 0; i < DIRECTED_N; i++)
            offer_reading(DIRECTED[i]);

        // random part over four pacing phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
                default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase
            repeat (RANDOM_PER_PH) begin
                pick      = $urandom_range(9);
                hum_code  = 14'($urandom_range(16383));
                temp_code = 14'($urandom_range(16383));
                // bias some items toward full humidity, zero degrees and 100 degrees
                if (pick == 0) hum_code = 14'($urandom_range(16383, 16370));
                if (pick == 1) temp_code = 14'($urandom_range(3985, 3955));
                if (pick == 2) temp_code = 14'($urandom_range(13905, 13880));
                row.hum_hi  = {2'($urandom_range(3)), hum_code[13:8]};
                row.hum_lo  = hum_code[7:0];
                row.temp_hi = temp_code[13:6];
                row.temp_lo = {temp_code[5:0], 2'($urandom_range(3))};
                row.typed   = 1'b0;
                row.len     = '0;
                row.text    = '0;
                offer_reading(row);
            end
        end
        rd_if.valid <= 1'b0;

        while (text_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d readings (%0d below zero, %0d at 100 degrees or more)",
                 readings_taken, below_zero_seen, hundreds_seen);
        $display("%0d text bytes checked under four sender/receiver pacing phases",
                 bytes_checked);
        if (mismatch_count == 0 && text_due.size() == 0) begin
            $display("tb_sensor_reading_to_display_text passed");
        end else begin
            $display("tb_sensor_reading_to_display_text failed");
        end
        $finish;
    end

endmodule
